// ===== design/gal_pkg.sv =====
// ----------------------------------------------------------------------------
// gal_pkg: shared types, constants and lookup functions
// Types, register indexes and font tables for the glyph address locator.
// ----------------------------------------------------------------------------
package gal_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 13;
  localparam int POS_W       = 13;

  localparam logic [7:0] ZONE_FIRST  = 8'hA1;
  localparam logic [7:0] ZONE_LAST   = 8'hF7;
  localparam logic [7:0] POS_LAST    = 8'hFE;
  localparam logic [7:0] HALF_LIMIT  = 8'h80;
  localparam logic [6:0] ROW_LEN     = 7'd94;
  localparam logic [6:0] ZONE_B0_OFS = 7'(8'hB0 - 8'hA1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HALF_KIND   = 3'd0,
    CFG_FULL_KIND   = 3'd1,
    CFG_HALF_WIDTH  = 3'd2,
    CFG_HALF_HEIGHT = 3'd3,
    CFG_FULL_WIDTH  = 3'd4,
    CFG_FULL_HEIGHT = 3'd5,
    CFG_HALF_BASE   = 3'd6,
    CFG_FULL_BASE   = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    HALF_ASCII   = 2'd0,
    HALF_PRINT   = 2'd1,
    HALF_SIXTEEN = 2'd2,
    HALF_NONE    = 2'd3
  } half_kind_t;

  typedef enum logic [1:0] {
    FULL_ALL     = 2'd0,
    FULL_STD     = 2'd1,
    FULL_COMPACT = 2'd2,
    FULL_NONE    = 2'd3
  } full_kind_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } in_item_t;

  typedef struct packed {
    logic               draw;
    logic               wide;
    logic [ADDR_W-1:0]  glyph_address;
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
  } out_item_t;

  typedef struct packed {
    half_kind_t        half_kind;
    full_kind_t        full_kind;
    logic [7:0]        half_width;
    logic [7:0]        half_height;
    logic [7:0]        full_width;
    logic [7:0]        full_height;
    logic [ADDR_W-1:0] half_base;
    logic [ADDR_W-1:0] full_base;
  } cfg_t;

  // first pipeline stage -> address stages
  typedef struct packed {
    logic               valid;
    logic               draw;
    logic               wide;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic [ADDR_W-1:0]  base;
  } dec_t;

  function automatic logic [6:0] half_first(input half_kind_t kind);
    case (kind)
      HALF_ASCII:   half_first = 7'd0;
      HALF_PRINT:   half_first = 7'd32;
      HALF_SIXTEEN: half_first = 7'd42;
      default:      half_first = 7'd0;
    endcase
  endfunction

  function automatic logic [7:0] half_count(input half_kind_t kind);
    case (kind)
      HALF_ASCII:   half_count = 8'd128;
      HALF_PRINT:   half_count = 8'd96;
      HALF_SIXTEEN: half_count = 8'd16;
      default:      half_count = 8'd0;
    endcase
  endfunction

  // zones A1..AF folded for the standard (col 0) and compact (col 1) layouts
  function automatic logic [6:0] low_zone_map(input logic [3:0] zone, input logic col);
    case (zone)
      4'd0:    low_zone_map = 7'd0;
      4'd1:    low_zone_map = 7'd1;
      4'd2:    low_zone_map = 7'd2;
      4'd3:    low_zone_map = col ? 7'd2 : 7'd3;
      4'd4:    low_zone_map = col ? 7'd2 : 7'd4;
      4'd5:    low_zone_map = col ? 7'd3 : 7'd5;
      4'd6:    low_zone_map = col ? 7'd3 : 7'd6;
      4'd7:    low_zone_map = col ? 7'd3 : 7'd7;
      default: low_zone_map = col ? 7'd4 : 7'd8;
    endcase
  endfunction

endpackage

// ===== design/gal_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gal_cfg_regs: configuration register file
// Holds the font kinds, glyph sizes and base addresses; write-only port.
// ----------------------------------------------------------------------------
module gal_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gal_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gal_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output gal_pkg::cfg_t                    cfg
);
  import gal_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_HALF_KIND:   cfg_nxt.half_kind   = half_kind_t'(cfg_wdata[1:0]);
        CFG_FULL_KIND:   cfg_nxt.full_kind   = full_kind_t'(cfg_wdata[1:0]);
        CFG_HALF_WIDTH:  cfg_nxt.half_width  = cfg_wdata[7:0];
        CFG_HALF_HEIGHT: cfg_nxt.half_height = cfg_wdata[7:0];
        CFG_FULL_WIDTH:  cfg_nxt.full_width  = cfg_wdata[7:0];
        CFG_FULL_HEIGHT: cfg_nxt.full_height = cfg_wdata[7:0];
        CFG_HALF_BASE:   cfg_nxt.half_base   = cfg_wdata[ADDR_W-1:0];
        CFG_FULL_BASE:   cfg_nxt.full_base   = cfg_wdata[ADDR_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_kind   <= HALF_ASCII;
      cfg_r.full_kind   <= FULL_ALL;
      cfg_r.half_width  <= 8'd8;
      cfg_r.half_height <= 8'd16;
      cfg_r.full_width  <= 8'd16;
      cfg_r.full_height <= 8'd16;
      cfg_r.half_base   <= '0;
      cfg_r.full_base   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/gal_decode.sv =====
// ----------------------------------------------------------------------------
// gal_decode: character code decode stage
// Maps a code to a glyph index, selects font size and base, forms byte count.
// ----------------------------------------------------------------------------
module gal_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  gal_pkg::in_item_t in_item,
  input  gal_pkg::cfg_t     cfg,
  output gal_pkg::dec_t     dec
);
  import gal_pkg::*;

  dec_t        dec_r;
  dec_t        dec_nxt;
  logic [7:0]  c1;
  logic [7:0]  c2;
  logic [6:0]  half_ofs;
  logic        half_hit;
  logic        code_ok;
  logic [6:0]  zone_raw;
  logic [6:0]  zone_adj;
  logic        col;
  logic [6:0]  row_pos;
  logic [POS_W-1:0] full_pos;
  logic [7:0]  sel_w;
  logic [7:0]  sel_h;

  always_comb begin
    c1 = in_item.first_byte;
    c2 = in_item.second_byte;

    // half width: index inside the kind's code range, else glyph 0
    half_ofs = c1[6:0] - half_first(cfg.half_kind);
    half_hit = (c1[6:0] >= half_first(cfg.half_kind)) &&
               ({1'b0, half_ofs} < half_count(cfg.half_kind));

    // GB2312
    code_ok  = (c1 >= ZONE_FIRST) && (c1 <= ZONE_LAST) &&
               (c2 >= ZONE_FIRST) && (c2 <= POS_LAST);
    zone_raw = 7'(c1 - ZONE_FIRST);
    row_pos  = 7'(c2 - ZONE_FIRST);
    col      = (cfg.full_kind == FULL_COMPACT);
    if (cfg.full_kind == FULL_ALL) begin
      zone_adj = zone_raw;
    end else if (zone_raw >= ZONE_B0_OFS) begin
      zone_adj = zone_raw - (col ? 7'd10 : 7'd6);
    end else begin
      zone_adj = low_zone_map(zone_raw[3:0], col);
    end
    full_pos = POS_W'(zone_adj) * POS_W'(ROW_LEN) + POS_W'(row_pos);

    dec_nxt       = '0;
    dec_nxt.valid = in_valid;
    dec_nxt.wide  = (c1 >= HALF_LIMIT);
    if (c1 < HALF_LIMIT) begin
      sel_w        = cfg.half_width;
      sel_h        = cfg.half_height;
      dec_nxt.draw = (cfg.half_kind != HALF_NONE);
      dec_nxt.pos  = half_hit ? POS_W'(half_ofs) : '0;
      dec_nxt.base = cfg.half_base;
    end else begin
      sel_w        = cfg.full_width;
      sel_h        = cfg.full_height;
      dec_nxt.draw = (cfg.full_kind != FULL_NONE);
      dec_nxt.pos  = code_ok ? full_pos : '0;
      dec_nxt.base = cfg.full_base;
    end
    // unsupported kind yields address 0
    if (!dec_nxt.draw) begin
      dec_nxt.pos  = '0;
      dec_nxt.base = '0;
    end
    dec_nxt.glyph_width  = sel_w;
    dec_nxt.glyph_height = sel_h;
    dec_nxt.byte_count   = COUNT_W'(6'(({1'b0, sel_w} + 9'd7) >> 3)) * COUNT_W'(sel_h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.valid <= 1'b0;
    end else begin
      dec_r.valid <= dec_nxt.valid;
    end
    dec_r.draw         <= dec_nxt.draw;
    dec_r.wide         <= dec_nxt.wide;
    dec_r.pos          <= dec_nxt.pos;
    dec_r.byte_count   <= dec_nxt.byte_count;
    dec_r.glyph_width  <= dec_nxt.glyph_width;
    dec_r.glyph_height <= dec_nxt.glyph_height;
    dec_r.base         <= dec_nxt.base;
  end

  assign dec = dec_r;

endmodule

// ===== design/gal_addr.sv =====
// ----------------------------------------------------------------------------
// gal_addr: glyph address stages
// Multiplies glyph index by byte count, then adds the font base address.
// ----------------------------------------------------------------------------
module gal_addr (
  input  logic               clk,
  input  logic               rst_n,
  input  gal_pkg::dec_t      dec,
  output logic               out_valid,
  output gal_pkg::out_item_t out_result
);
  import gal_pkg::*;

  localparam int PROD_W = POS_W + COUNT_W;

  // multiply stage
  dec_t              mul_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  // output stage
  logic              valid_r;
  out_item_t         res_r;
  out_item_t         res_nxt;

  assign prod_nxt = PROD_W'(dec.pos) * PROD_W'(dec.byte_count);

  always_comb begin
    res_nxt.draw          = mul_r.draw;
    res_nxt.wide          = mul_r.wide;
    res_nxt.glyph_address = mul_r.base + ADDR_W'(prod_r);
    res_nxt.byte_count    = mul_r.byte_count;
    res_nxt.glyph_width   = mul_r.glyph_width;
    res_nxt.glyph_height  = mul_r.glyph_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r.valid <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      mul_r.valid <= dec.valid;
      valid_r     <= mul_r.valid;
    end
    mul_r.draw         <= dec.draw;
    mul_r.wide         <= dec.wide;
    mul_r.pos          <= dec.pos;
    mul_r.byte_count   <= dec.byte_count;
    mul_r.glyph_width  <= dec.glyph_width;
    mul_r.glyph_height <= dec.glyph_height;
    mul_r.base         <= dec.base;
    prod_r             <= prod_nxt;
    res_r              <= res_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = res_r;

endmodule

// ===== design/glyph_address_locator.sv =====
// ----------------------------------------------------------------------------
// glyph_address_locator: font glyph address lookup
// Turns a one- or two-byte character code into a glyph address and size.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data (first_byte, second_byte) and raise start; the code
//   is taken at each rising edge with start high and busy low. busy is high
//   only while rst_n is low and for the first cycle after reset.
//   Output: out_valid strobes for one cycle with out_result (draw, wide,
//   glyph_address, byte_count, glyph_width, glyph_height). There is no
//   backpressure; each result must be captured in its strobe cycle.
//   Pipeline: three registers (decode, index multiply, base add) lie between
//   the transfer edge and the out_valid strobe.
//   Throughput: one code per clock while busy is low, set by the three-stage
//   pipeline; the index by byte count multiply has a stage of its own.
//   Config: cfg_we writes cfg_wdata into register cfg_index; write only
//   while the pipeline is empty.
//   Reset: synchronous; empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module glyph_address_locator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  gal_pkg::in_item_t               in_data,
  output logic                            out_valid,
  output gal_pkg::out_item_t              out_result,
  input  logic                            cfg_we,
  input  logic [gal_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gal_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gal_pkg::*;

  cfg_t cfg;
  dec_t dec;
  logic busy_r;
  logic in_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r || !rst_n;
  assign in_accept = start && !busy;

  gal_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gal_decode u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .in_item  (in_data),
    .cfg      (cfg),
    .dec      (dec)
  );

  gal_addr u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec        (dec),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // one result per transfer
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    ##3 (out_valid == $past(in_accept, 3)))
    else $error("result strobe does not match input transfer");

  // unsupported font kind reports address 0
  a_nodraw_addr : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result.draw) |-> (out_result.glyph_address == '0))
    else $error("undrawn glyph with nonzero address");

  // byte count never exceeds 32 columns of bytes by 255 rows
  a_count_max : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.byte_count <= 13'd8160))
    else $error("byte count out of range");

  // codes below 0x80 give half-width (not wide) results
  a_wide_src : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_data.first_byte < HALF_LIMIT)) |-> ##3 (out_valid && !out_result.wide))
    else $error("half-width code reported wide");

endmodule
